### sv/pl_win_pkg.sv
// ---------------------------------------------------------------------------
// pl_win_pkg
// Shared types, codes and constants of the locus neighborhood window block.
// ---------------------------------------------------------------------------
package pl_win_pkg;

    localparam int unsigned STORE_DEPTH_DEF = 64;

    localparam int unsigned REQ_W    = 2;
    localparam int unsigned CHROM_W  = 10;
    localparam int unsigned POS_W    = 32;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned NIDX_W   = 6;

    // request codes
    localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_GET   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_NEIGHBOUR = 3'd0;
    localparam logic [STATUS_W-1:0] ST_END       = 3'd1;
    localparam logic [STATUS_W-1:0] ST_LOADED    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_CLEARED   = 3'd4;

    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [CHROM_W-1:0] chrom_index;
        logic [POS_W-1:0]   position;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [NIDX_W-1:0]   neighbour_index;
        logic [CHROM_W-1:0]  neighbour_chrom;
        logic [POS_W-1:0]    neighbour_pos;
        logic                is_centre;
        logic                last;
    } t_resp;

    typedef struct packed {
        logic [CHROM_W-1:0] chrom;
        logic [POS_W-1:0]   pos;
    } t_locus;

endpackage

### sv/proximal_locus_window_top.sv
// ---------------------------------------------------------------------------
// proximal_locus_window_top
// Locus store with a neighborhood scan around a moving cursor.
// ---------------------------------------------------------------------------
// A load or clear request is taken while idle and its single result shows
// on the next cycle. A get reads the centre locus, then scans downward and
// upward one stored locus per cycle, then reads out the run one locus per
// cycle. The single read port of the locus memory sets that pace, and
// one subtract and compare unit checks each scanned locus. busy is high
// for the whole get. Results are pulsed on o_strobe for one cycle each
// and the receiver cannot stall them; the last result of a request carries
// last = 1. A get past the last stored locus answers end of loci; request
// code 3 is dropped with no result. max_gap may be written at any time the
// block is idle.
// ---------------------------------------------------------------------------
module proximal_locus_window_top #(
    parameter int unsigned STORE_DEPTH = pl_win_pkg::STORE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  pl_win_pkg::t_req              i_req,
    output logic                          o_strobe,
    output pl_win_pkg::t_resp             o_result,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [pl_win_pkg::POS_W-1:0]  i_cfg_data
);

    localparam int unsigned IDX_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(STORE_DEPTH + 1);
    localparam int unsigned POS_W = pl_win_pkg::POS_W;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_CTR  = 5'b00010,
        S_DOWN = 5'b00100,
        S_UP   = 5'b01000,
        S_EMIT = 5'b10000
    } t_state;

    pl_win_pkg::t_locus mem [STORE_DEPTH];
    pl_win_pkg::t_locus r_rd_data;
    logic [IDX_W-1:0]   rd_addr;
    logic               mem_we;

    t_state                        r_state, n_state;
    logic [CNT_W-1:0]              r_count, n_count;
    logic [CNT_W-1:0]              r_cursor, n_cursor;
    logic [IDX_W-1:0]              r_ptr, n_ptr;
    logic [IDX_W-1:0]              r_lo, n_lo;
    logic [IDX_W-1:0]              r_hi, n_hi;
    logic [pl_win_pkg::CHROM_W-1:0] r_cchr, n_cchr;
    logic [POS_W-1:0]              r_cpos, n_cpos;
    logic [POS_W-1:0]              r_max_gap;
    logic                          r_strobe, n_strobe;
    pl_win_pkg::t_resp             r_result, n_result;

    // shared distance unit
    logic [POS_W-1:0] op_far, op_near;
    logic [POS_W:0]   diff;
    logic [POS_W-1:0] gap;
    logic             near;

    logic             up_begin, emit_begin;
    logic [IDX_W-1:0] cidx;

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_strobe    = r_strobe;
    assign o_result    = r_result;
    assign cidx        = r_cursor[IDX_W-1:0];

    always_comb begin
        if (r_state == S_UP) begin
            op_far  = r_rd_data.pos;
            op_near = r_cpos;
        end else begin
            op_far  = r_cpos;
            op_near = r_rd_data.pos;
        end
        diff = {1'b0, op_far} - {1'b0, op_near};
        gap  = diff[POS_W-1:0] - POS_W'(1);
        // a gap below zero never qualifies
        near = (r_rd_data.chrom == r_cchr) && !diff[POS_W] &&
               (diff[POS_W-1:0] != '0) && (gap <= r_max_gap);
    end

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_cursor   = r_cursor;
        n_ptr      = r_ptr;
        n_lo       = r_lo;
        n_hi       = r_hi;
        n_cchr     = r_cchr;
        n_cpos     = r_cpos;
        n_strobe   = 1'b0;
        n_result   = '0;
        mem_we     = 1'b0;
        rd_addr    = r_ptr;
        up_begin   = 1'b0;
        emit_begin = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_result.last = 1'b1;
                    case (i_req.req_type)
                        pl_win_pkg::REQ_LOAD: begin
                            n_strobe = 1'b1;
                            if (r_count == CNT_W'(STORE_DEPTH)) begin
                                n_result.status = pl_win_pkg::ST_FULL;
                            end else begin
                                mem_we          = 1'b1;
                                n_count         = r_count + CNT_W'(1);
                                n_result.status = pl_win_pkg::ST_LOADED;
                            end
                        end
                        pl_win_pkg::REQ_GET: begin
                            if (r_cursor >= r_count) begin
                                n_strobe        = 1'b1;
                                n_result.status = pl_win_pkg::ST_END;
                            end else begin
                                rd_addr = cidx;
                                n_ptr   = cidx;
                                n_state = S_CTR;
                            end
                        end
                        pl_win_pkg::REQ_CLEAR: begin
                            n_strobe        = 1'b1;
                            n_count         = '0;
                            n_cursor        = '0;
                            n_ptr           = '0;
                            n_result.status = pl_win_pkg::ST_CLEARED;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_CTR: begin
                n_cchr = r_rd_data.chrom;
                n_cpos = r_rd_data.pos;
                if (r_ptr == '0) begin
                    n_lo     = '0;
                    up_begin = 1'b1;
                end else begin
                    rd_addr = r_ptr - IDX_W'(1);
                    n_state = S_DOWN;
                end
            end
            S_DOWN: begin
                if (near) begin
                    n_ptr = r_ptr - IDX_W'(1);
                    if (r_ptr == IDX_W'(1)) begin
                        n_lo     = '0;
                        up_begin = 1'b1;
                    end else begin
                        rd_addr = r_ptr - IDX_W'(2);
                    end
                end else begin
                    n_lo     = r_ptr;
                    up_begin = 1'b1;
                end
            end
            S_UP: begin
                if (near) begin
                    n_ptr = r_ptr + IDX_W'(1);
                    if (CNT_W'(r_ptr) + CNT_W'(2) >= r_count) begin
                        n_hi       = r_ptr + IDX_W'(1);
                        emit_begin = 1'b1;
                    end else begin
                        rd_addr = r_ptr + IDX_W'(2);
                    end
                end else begin
                    n_hi       = r_ptr;
                    emit_begin = 1'b1;
                end
            end
            S_EMIT: begin
                n_strobe                 = 1'b1;
                n_result.status          = pl_win_pkg::ST_NEIGHBOUR;
                n_result.neighbour_index = pl_win_pkg::NIDX_W'(r_ptr);
                n_result.neighbour_chrom = r_rd_data.chrom;
                n_result.neighbour_pos   = r_rd_data.pos;
                n_result.is_centre       = (CNT_W'(r_ptr) == r_cursor);
                n_result.last            = (r_ptr == r_hi);
                if (r_ptr == r_hi) begin
                    n_cursor = r_cursor + CNT_W'(1);
                    n_state  = S_IDLE;
                end else begin
                    rd_addr = r_ptr + IDX_W'(1);
                    n_ptr   = r_ptr + IDX_W'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // upward scan restarts from the centre
        if (up_begin) begin
            n_ptr = cidx;
            if (CNT_W'(cidx) + CNT_W'(1) >= r_count) begin
                n_hi       = cidx;
                emit_begin = 1'b1;
            end else begin
                rd_addr = cidx + IDX_W'(1);
                n_state = S_UP;
            end
        end

        if (emit_begin) begin
            n_ptr   = n_lo;
            rd_addr = n_lo;
            n_state = S_EMIT;
        end
    end

    // locus memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_count[IDX_W-1:0]] <= '{chrom: i_req.chrom_index, pos: i_req.position};
        end
        r_rd_data <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_cursor  <= '0;
            r_ptr     <= '0;
            r_strobe  <= 1'b0;
            r_max_gap <= '0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_cursor <= n_cursor;
            r_ptr    <= n_ptr;
            r_strobe <= n_strobe;
            if (i_cfg_valid && o_cfg_ready) begin
                r_max_gap <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_cchr   <= n_cchr;
        r_cpos   <= n_cpos;
        r_result <= n_result;
    end

endmodule

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the locus neighborhood window block: loads sorted
// and unsorted loci, walks the cursor with get requests, clears the store and
// overfills it, and checks every result strobe against a built-in predictor.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned DEPTH        = pl_win_pkg::STORE_DEPTH_DEF;
    localparam int unsigned STALL_LIMIT  = 2000;
    localparam int unsigned RANDOM_ITEMS = 500;
    localparam int unsigned QUIET_TAIL   = 60;

    // request code the block drops without a result
    localparam logic [pl_win_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;

    // predicts the results of each accepted request and checks the strobes
    class locus_scoreboard;
        bit [pl_win_pkg::CHROM_W-1:0] chrom_mem [DEPTH];
        bit [pl_win_pkg::POS_W-1:0]   pos_mem [DEPTH];
        int unsigned                  n_loci;
        int unsigned                  cursor_idx;
        bit [pl_win_pkg::POS_W-1:0]   gap_limit;
        pl_win_pkg::t_resp            pending_q [$];
        int unsigned                  n_errors;
        int unsigned                  n_checked;
        int unsigned                  n_neighbours;
        int unsigned                  n_full;
        int unsigned                  n_end;

        function new();
            n_loci       = 0;
            cursor_idx   = 0;
            gap_limit    = '0;
            n_errors     = 0;
            n_checked    = 0;
            n_neighbours = 0;
            n_full       = 0;
            n_end        = 0;
        endfunction

        function void set_gap_limit(bit [pl_win_pkg::POS_W-1:0] v);
            gap_limit = v;
        endfunction

        function int unsigned pending();
            return pending_q.size();
        endfunction

        function void enqueue(pl_win_pkg::t_resp r);
            pending_q = {pending_q, r};
        endfunction

        // a negative gap (not beyond the centre in scan direction) is too far
        function bit reachable(int unsigned c, int unsigned f, bit toward_lower);
            longint gap;
            if (chrom_mem[f] != chrom_mem[c]) return 1'b0;
            if (toward_lower) begin
                gap = longint'({32'b0, pos_mem[c]}) - longint'({32'b0, pos_mem[f]}) - 1;
            end else begin
                gap = longint'({32'b0, pos_mem[f]}) - longint'({32'b0, pos_mem[c]}) - 1;
            end
            if (gap < 0) return 1'b0;
            return gap <= longint'({32'b0, gap_limit});
        endfunction

        function void add_single(logic [pl_win_pkg::STATUS_W-1:0] st);
            pl_win_pkg::t_resp r;
            r        = '0;
            r.status = st;
            r.last   = 1'b1;
            enqueue(r);
        endfunction

        function void note_request(pl_win_pkg::t_req q);
            pl_win_pkg::t_resp r;
            int unsigned       lo;
            int unsigned       hi;
            case (q.req_type)
                pl_win_pkg::REQ_LOAD: begin
                    if (n_loci >= DEPTH) begin
                        n_full++;
                        add_single(pl_win_pkg::ST_FULL);
                    end else begin
                        chrom_mem[n_loci] = q.chrom_index;
                        pos_mem[n_loci]   = q.position;
                        n_loci++;
                        add_single(pl_win_pkg::ST_LOADED);
                    end
                end
                pl_win_pkg::REQ_CLEAR: begin
                    n_loci     = 0;
                    cursor_idx = 0;
                    add_single(pl_win_pkg::ST_CLEARED);
                end
                pl_win_pkg::REQ_GET: begin
                    if (cursor_idx >= n_loci) begin
                        n_end++;
                        add_single(pl_win_pkg::ST_END);
                    end else begin
                        lo = cursor_idx;
                        while (lo > 0 && reachable(cursor_idx, lo - 1, 1'b1)) lo--;
                        hi = cursor_idx;
                        while (hi + 1 < n_loci && reachable(cursor_idx, hi + 1, 1'b0)) hi++;
                        for (int unsigned i = lo; i <= hi; i++) begin
                            r                 = '0;
                            r.status          = pl_win_pkg::ST_NEIGHBOUR;
                            r.neighbour_index = i[pl_win_pkg::NIDX_W-1:0];
                            r.neighbour_chrom = chrom_mem[i];
                            r.neighbour_pos   = pos_mem[i];
                            r.is_centre       = (i == cursor_idx);
                            r.last            = (i == hi);
                            enqueue(r);
                            n_neighbours++;
                        end
                        cursor_idx++;
                    end
                end
                default: ; // undefined code, dropped by the block
            endcase
        endfunction

        function void check_result(pl_win_pkg::t_resp got);
            pl_win_pkg::t_resp want;
            n_checked++;
            if (pending_q.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("[%0t] unexpected result st=%0d idx=%0d chrom=%0d pos=%h c=%b l=%b",
                             $realtime, got.status, got.neighbour_index, got.neighbour_chrom,
                             got.neighbour_pos, got.is_centre, got.last);
                return;
            end
            want = pending_q.pop_front();
            if (got.status !== want.status || got.neighbour_index !== want.neighbour_index ||
                got.neighbour_chrom !== want.neighbour_chrom ||
                got.neighbour_pos !== want.neighbour_pos ||
                got.is_centre !== want.is_centre || got.last !== want.last) begin
                n_errors++;
                if (n_errors <= 10) begin
                    $display("[%0t] mismatch exp st=%0d idx=%0d chrom=%0d pos=%h c=%b l=%b",
                             $realtime, want.status, want.neighbour_index, want.neighbour_chrom,
                             want.neighbour_pos, want.is_centre, want.last);
                    $display("           got st=%0d idx=%0d chrom=%0d pos=%h c=%b l=%b",
                             got.status, got.neighbour_index, got.neighbour_chrom,
                             got.neighbour_pos, got.is_centre, got.last);
                end
            end
        endfunction
    endclass

    logic                         i_clk       = 1'b0;
    logic                         i_rst_n     = 1'b0;
    logic                         start       = 1'b0;
    logic                         busy;
    pl_win_pkg::t_req             i_req       = '0;
    logic                         o_strobe;
    pl_win_pkg::t_resp            o_result;
    logic                         i_cfg_valid = 1'b0;
    logic                         o_cfg_ready;
    logic [pl_win_pkg::POS_W-1:0] i_cfg_data  = '0;

    locus_scoreboard              sb = new();
    int unsigned                  items_sent  = 0;
    int unsigned                  gap_writes  = 0;
    int unsigned                  stall_count = 0;
    bit                           idle_on     = 1'b1;
    bit [pl_win_pkg::POS_W-1:0]   cur_gap     = '0;

    proximal_locus_window_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_strobe    (o_strobe),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // observe every transaction at the edge that completes it
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe) sb.check_result(o_result);
            if (start && !busy) sb.note_request(i_req);
            if (i_cfg_valid && o_cfg_ready) sb.set_gap_limit(i_cfg_data);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe || (i_cfg_valid && o_cfg_ready)) begin
            stall_count <= 0;
        end else if (stall_count + 1 >= STALL_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                     STALL_LIMIT, sb.pending());
            $display("testbench: errors");
            $finish;
        end else begin
            stall_count <= stall_count + 1;
        end
    end

    function automatic logic [pl_win_pkg::CHROM_W-1:0] rand_chrom();
        logic [31:0] v;
        v = $urandom;
        return v[pl_win_pkg::CHROM_W-1:0];
    endfunction

    // called in the time step of a rising edge; returns at the accepting edge
    task automatic push_request(pl_win_pkg::t_req q);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= q;
        do @(posedge i_clk); while (busy);
        if (q.req_type != REQ_UNUSED) items_sent++;
    endtask

    task automatic send_item(logic [pl_win_pkg::REQ_W-1:0] kind,
                             logic [pl_win_pkg::CHROM_W-1:0] ch,
                             logic [pl_win_pkg::POS_W-1:0] p);
        pl_win_pkg::t_req q;
        q.req_type    = kind;
        q.chrom_index = ch;
        q.position    = p;
        push_request(q);
    endtask

    // a dropped request has no result, so idle time is added after the last one
    task automatic wait_idle();
        start <= 1'b0;
        while (sb.pending() != 0 || busy) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_gap(bit [pl_win_pkg::POS_W-1:0] v);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cur_gap = v;
        gap_writes++;
    endtask

    // clear, load a mostly sorted run of loci, then walk the cursor past the end
    task automatic run_locus_set(int unsigned n_set, bit overfill);
        bit [pl_win_pkg::CHROM_W-1:0] ch;
        bit [pl_win_pkg::POS_W-1:0]   p;
        longint unsigned              step;
        longint unsigned              span;
        send_item(pl_win_pkg::REQ_CLEAR, rand_chrom(), $urandom);
        ch   = rand_chrom();
        p    = ($urandom_range(0, 1) != 0) ? $urandom : ($urandom >> 1);
        span = 2 * longint'({32'b0, cur_gap}) + 3;
        for (int unsigned k = 0; k < n_set + (overfill ? 2 : 0); k++) begin
            if (k != 0) begin
                case ($urandom_range(0, 9))
                    0:       step = 0;
                    1, 2:    step = longint'({32'b0, cur_gap}) + 1;
                    3:       step = longint'({32'b0, cur_gap}) + 2;
                    4:       step = 1;
                    default: step = 1 + (longint'({32'b0, $urandom}) % span);
                endcase
                if ($urandom_range(0, 7) == 0)
                    ch = ($urandom_range(0, 3) == 0) ? rand_chrom() : ch + 10'd1;
                if ($urandom_range(0, 19) == 0) p = $urandom;
                else p = p + step[pl_win_pkg::POS_W-1:0];
            end
            if ($urandom_range(0, 24) == 0)
                send_item(REQ_UNUSED, rand_chrom(), $urandom);
            send_item(pl_win_pkg::REQ_LOAD, ch, p);
        end
        for (int unsigned k = 0; k <= n_set; k++) begin
            if ($urandom_range(0, 14) == 0)
                send_item(($urandom_range(0, 1) != 0) ? REQ_UNUSED : pl_win_pkg::REQ_LOAD,
                          rand_chrom(), $urandom);
            send_item(pl_win_pkg::REQ_GET, rand_chrom(), $urandom);
        end
    endtask

    initial begin
        int unsigned                n_set;
        int unsigned                phase;
        bit [pl_win_pkg::POS_W-1:0] g;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: max_gap still at its reset value of zero
        send_item(pl_win_pkg::REQ_GET, 10'd0, 32'd0);
        send_item(pl_win_pkg::REQ_LOAD, 10'd0, 32'd0);
        send_item(pl_win_pkg::REQ_LOAD, 10'd0, 32'd1);
        send_item(pl_win_pkg::REQ_LOAD, 10'd0, 32'd1);
        send_item(pl_win_pkg::REQ_LOAD, 10'd0, 32'd3);
        send_item(REQ_UNUSED, 10'h3FF, 32'hFFFF_FFFF);
        send_item(pl_win_pkg::REQ_LOAD, 10'd1023, 32'hFFFF_FFFF);
        send_item(pl_win_pkg::REQ_LOAD, 10'd1023, 32'hFFFF_FFFE);
        repeat (7) send_item(pl_win_pkg::REQ_GET, 10'd0, 32'd0);
        send_item(pl_win_pkg::REQ_CLEAR, 10'd0, 32'd0);

        // widest window: the whole position range on one chromosome
        write_gap(32'hFFFF_FFFF);
        send_item(pl_win_pkg::REQ_LOAD, 10'd5, 32'd0);
        send_item(pl_win_pkg::REQ_LOAD, 10'd5, 32'hFFFF_FFFF);
        send_item(pl_win_pkg::REQ_LOAD, 10'd6, 32'hFFFF_FFFF);
        repeat (4) send_item(pl_win_pkg::REQ_GET, 10'h3FF, 32'hFFFF_FFFF);
        send_item(pl_win_pkg::REQ_CLEAR, 10'h3FF, 32'hFFFF_FFFF);

        phase = 0;
        while (items_sent < RANDOM_ITEMS) begin
            if (phase % 3 == 0) begin
                case ($urandom_range(0, 5))
                    0:       g = '0;
                    1:       g = 32'hFFFF_FFFF;
                    2:       g = $urandom_range(1, 3);
                    3:       g = $urandom_range(0, 1000);
                    4:       g = $urandom;
                    default: g = 32'hFFFF_FFFE;
                endcase
                write_gap((phase == 0) ? 32'd0 : g);
            end
            idle_on = ($urandom_range(0, 3) != 0) && (items_sent + QUIET_TAIL < RANDOM_ITEMS);
            // a full store only while there is room left for one
            n_set   = ((phase == 1 || $urandom_range(0, 9) == 0) &&
                       (items_sent + 3 * DEPTH < RANDOM_ITEMS)) ? DEPTH : $urandom_range(1, 12);
            run_locus_set(n_set, (n_set == DEPTH) && (phase == 1 || $urandom_range(0, 1) != 0));
            phase++;
        end

        wait_idle();
        repeat (10) @(posedge i_clk);
        $display("covered %0d requests, %0d max_gap writes, %0d neighbour results",
                 items_sent, gap_writes, sb.n_neighbours);
        $display("%0d results checked, %0d store-full rejects, %0d end-of-loci answers",
                 sb.n_checked, sb.n_full, sb.n_end);
        if (sb.n_errors == 0 && sb.pending() == 0) begin
            $display("testbench: clean");
        end else begin
            $display("%0d mismatches", sb.n_errors);
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

### files.f
sv/pl_win_pkg.sv
sv/proximal_locus_window_top.sv
dv/testbench.sv
